// ===== hdl/mtwg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwg_pkg: shared definitions of the multi-tone wave generator
// sizes, register indexes, sine coefficients and the sequencer states
// ----------------------------------------------------------------------------
package mtwg_pkg;

   // number of tone components and sine table address width
   localparam int Components   = 4;
   localparam int SineAddrBits = 12;

   // configuration register file
   localparam int SetupRegs = 4;
   localparam int SetupW    = 49;
   localparam int GainW     = 16;
   localparam int UsedW     = 3;
   localparam int IndexW    = 3;

   localparam logic [IndexW-1:0] REG_SETUP_A = 3'd0;
   localparam logic [IndexW-1:0] REG_SETUP_B = 3'd1;
   localparam logic [IndexW-1:0] REG_SETUP_C = 3'd2;
   localparam logic [IndexW-1:0] REG_SETUP_D = 3'd3;
   localparam logic [IndexW-1:0] REG_GAIN    = 3'd4;
   localparam logic [IndexW-1:0] REG_USED    = 3'd5;

   localparam logic [GainW-1:0] GainReset = 16'd4096;

   // component counter and phase index widths
   localparam int CntW = $clog2(Components + 1);
   localparam int IdxW = (Components > 1) ? $clog2(Components) : 1;

   // shared multiplier operand and product widths
   localparam int MulAW = 33;
   localparam int MulBW = 18;
   localparam int ProdW = MulAW + MulBW;
   localparam int SumW  = 33;

   // sine polynomial coefficients, unsigned
   localparam logic [15:0] CoefC3 = 16'd153;
   localparam logic [15:0] CoefC2 = 16'd2611;
   localparam logic [15:0] CoefC1 = 16'd21167;
   localparam logic [15:0] CoefC0 = 16'd51472;

   localparam logic signed [15:0] SquareLevel = 16'sd16384;

   // output range of a signed 32-bit sample
   localparam logic signed [ProdW-1:0] SampleMax = ProdW'(2147483647);
   localparam logic signed [ProdW-1:0] SampleMin = -ProdW'(2147483647) - ProdW'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_POLY1,
      ST_POLY2,
      ST_POLY3,
      ST_MAG,
      ST_AMP,
      ST_FINAL,
      ST_GAIN,
      ST_RESULT
   } state_type;

endpackage

// ===== hdl/mtwg_mul.sv =====
// ----------------------------------------------------------------------------
// mtwg_mul: shared signed multiplier
// one signed product per cycle, registered at the output
// ----------------------------------------------------------------------------
module mtwg_mul (
   input  logic                                 clock,
   input  logic signed [mtwg_pkg::MulAW-1:0]    mul_a,
   input  logic signed [mtwg_pkg::MulBW-1:0]    mul_b,
   output logic signed [mtwg_pkg::ProdW-1:0]    prod
);

   logic signed [mtwg_pkg::ProdW-1:0] prod_ff;
   logic signed [mtwg_pkg::ProdW-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/multi_tone_wave_generator.sv =====
// ----------------------------------------------------------------------------
// multi_tone_wave_generator: four-tone direct digital synthesiser
// sums sine or square tones into one saturated Q16.16 sample per tick
// ----------------------------------------------------------------------------
// usage
//  - req channel: one transaction per sample period; req_tick high advances
//    every phase accumulator and produces one sample, req_tick low is taken
//    and produces nothing
//  - rsp channel: rsp_sample_value (signed Q16.16) and rsp_saturated
//  - csr channel: always ready; index 0..3 tone setups, 4 master gain,
//    5 number of tones used; write only while the block is idle
// timing
//  - one shared multiplier does all the work: six products per used tone
//    (four for the sine polynomial, one for the magnitude, one for the
//    amplitude) plus one for the master gain
//  - a tick runs the square, polynomial, magnitude and amplitude steps for each
//    used tone, then the final sum, gain and result steps (gain and result alone
//    with none used); the next tick is taken only once the sequencer is idle;
//    req_stall is high while a sample is being worked out
// reset
//  - synchronous, active high: phases cleared, setups 0, gain 1.0, no tones
// back-pressure
//  - the result sits in an output register; the next tick is taken while it
//    waits, and the sequencer holds its last step until the register frees
// ----------------------------------------------------------------------------
module multi_tone_wave_generator (
   input  logic                                clock,
   input  logic                                reset,
   // tick transactions
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_tick,
   // sample transactions
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_sample_value,
   output logic                                rsp_saturated,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mtwg_pkg::IndexW-1:0]         csr_index,
   input  logic [mtwg_pkg::SetupW-1:0]         csr_wdata
);

   // sine address mask on the top 16 phase bits
   localparam logic [15:0] SineMask =
      16'(~((32'd1 << (16 - mtwg_pkg::SineAddrBits)) - 32'd1));
   localparam logic [mtwg_pkg::UsedW-1:0] UsedMax = mtwg_pkg::UsedW'(mtwg_pkg::Components);

   // configuration registers
   logic [mtwg_pkg::SetupW-1:0]       setup_ff [mtwg_pkg::SetupRegs];
   logic [mtwg_pkg::GainW-1:0]        gain_ff;
   logic [mtwg_pkg::UsedW-1:0]        used_ff;

   // phase accumulators
   logic [31:0]                       phase_ff [mtwg_pkg::Components];

   // sequencer
   mtwg_pkg::state_type               state_ff, state_in;
   logic [mtwg_pkg::CntW-1:0]         comp_ff, comp_in;
   logic signed [mtwg_pkg::SumW-1:0]  sum_ff, sum_in;
   logic [14:0]                       t_ff, t_in;
   logic [1:0]                        q_ff, q_in;
   logic [14:0]                       t2_ff, t2_in;
   logic                              advance;
   logic                              load_rsp;

   // output register
   logic                              rsp_valid_ff;
   logic signed [31:0]                rsp_sample_ff;
   logic                              rsp_sat_ff;

   // shared multiplier
   logic signed [mtwg_pkg::MulAW-1:0] mul_a;
   logic signed [mtwg_pkg::MulBW-1:0] mul_b;
   logic signed [mtwg_pkg::ProdW-1:0] prod;

   // datapath around the multiplier
   logic [mtwg_pkg::UsedW-1:0]        used_eff;
   logic [mtwg_pkg::SetupW-1:0]       setup_cur;
   logic [15:0]                       x_phase;
   logic [1:0]                        q_calc;
   logic [13:0]                       f_calc;
   logic [14:0]                       t_calc;
   logic [16:0]                       prod_hi;
   logic [14:0]                       mag;
   logic signed [15:0]                half_mag;
   logic signed [15:0]                tone_v;
   logic signed [15:0]                amp;
   logic signed [15:0]                gain;
   logic signed [mtwg_pkg::ProdW-1:0] y_wide;
   logic                              y_sat;
   logic signed [31:0]                y_clip;

   mtwg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // tones beyond the implemented count are ignored
   assign used_eff  = (used_ff > UsedMax) ? UsedMax : used_ff;
   assign setup_cur = setup_ff[2'(comp_ff)];
   assign amp       = setup_cur[47:32];
   assign gain      = gain_ff;

   // fold the phase into the first quadrant
   assign x_phase = phase_ff[comp_ff[mtwg_pkg::IdxW-1:0]][31:16] & SineMask;
   assign q_calc  = x_phase[15:14];
   assign f_calc  = x_phase[13:0];
   assign t_calc  = q_calc[0] ? (15'd16384 - {1'b0, f_calc}) : {1'b0, f_calc};

   // Q14 scaling of the previous product, magnitude clamp and halving
   assign prod_hi  = prod[30:14];
   assign mag      = (prod_hi > 17'd32767) ? 15'h7fff : prod_hi[14:0];
   assign half_mag = {2'b00, mag[14:1]};

   // square mode takes the sign only; an exact zero counts as positive
   always_comb begin
      if (setup_cur[48]) begin
         tone_v = (q_ff[1] && (mag != 15'd0)) ? -mtwg_pkg::SquareLevel
                                               : mtwg_pkg::SquareLevel;
      end else begin
         tone_v = q_ff[1] ? -half_mag : half_mag;
      end
   end

   // floor shift of the gained sum and saturation
   assign y_wide = prod >>> 23;
   assign y_sat  = (y_wide > mtwg_pkg::SampleMax) || (y_wide < mtwg_pkg::SampleMin);
   always_comb begin
      if (y_wide > mtwg_pkg::SampleMax) begin
         y_clip = mtwg_pkg::SampleMax[31:0];
      end else if (y_wide < mtwg_pkg::SampleMin) begin
         y_clip = mtwg_pkg::SampleMin[31:0];
      end else begin
         y_clip = y_wide[31:0];
      end
   end

   // sequencer: next state and multiplier operands
   always_comb begin
      state_in = state_ff;
      comp_in  = comp_ff;
      sum_in   = sum_ff;
      t_in     = t_ff;
      q_in     = q_ff;
      t2_in    = t2_ff;
      mul_a    = '0;
      mul_b    = '0;
      advance  = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         mtwg_pkg::ST_IDLE: begin
            if (req_valid && req_tick) begin
               advance  = 1'b1;
               comp_in  = '0;
               sum_in   = '0;
               state_in = (used_eff == '0) ? mtwg_pkg::ST_GAIN : mtwg_pkg::ST_SQUARE;
            end
         end
         mtwg_pkg::ST_SQUARE: begin
            // fold in the previous tone's contribution
            if (comp_ff != '0) begin
               sum_in = sum_ff + $signed(prod[mtwg_pkg::SumW-1:0]);
            end
            t_in     = t_calc;
            q_in     = q_calc;
            mul_a    = mtwg_pkg::MulAW'(t_calc);
            mul_b    = mtwg_pkg::MulBW'(t_calc);
            state_in = mtwg_pkg::ST_POLY1;
         end
         mtwg_pkg::ST_POLY1: begin
            t2_in    = prod[28:14];
            mul_a    = mtwg_pkg::MulAW'(prod[28:14]);
            mul_b    = mtwg_pkg::MulBW'(mtwg_pkg::CoefC3);
            state_in = mtwg_pkg::ST_POLY2;
         end
         mtwg_pkg::ST_POLY2: begin
            mul_a    = mtwg_pkg::MulAW'(t2_ff);
            mul_b    = mtwg_pkg::MulBW'(mtwg_pkg::CoefC2 - prod_hi[15:0]);
            state_in = mtwg_pkg::ST_POLY3;
         end
         mtwg_pkg::ST_POLY3: begin
            mul_a    = mtwg_pkg::MulAW'(t2_ff);
            mul_b    = mtwg_pkg::MulBW'(mtwg_pkg::CoefC1 - prod_hi[15:0]);
            state_in = mtwg_pkg::ST_MAG;
         end
         mtwg_pkg::ST_MAG: begin
            mul_a    = mtwg_pkg::MulAW'(t_ff);
            mul_b    = mtwg_pkg::MulBW'(mtwg_pkg::CoefC0 - prod_hi[15:0]);
            state_in = mtwg_pkg::ST_AMP;
         end
         mtwg_pkg::ST_AMP: begin
            mul_a   = mtwg_pkg::MulAW'(tone_v);
            mul_b   = mtwg_pkg::MulBW'(amp);
            comp_in = comp_ff + mtwg_pkg::CntW'(1);
            if ((mtwg_pkg::UsedW'(comp_ff) + mtwg_pkg::UsedW'(1)) == used_eff) begin
               state_in = mtwg_pkg::ST_FINAL;
            end else begin
               state_in = mtwg_pkg::ST_SQUARE;
            end
         end
         mtwg_pkg::ST_FINAL: begin
            sum_in   = sum_ff + $signed(prod[mtwg_pkg::SumW-1:0]);
            state_in = mtwg_pkg::ST_GAIN;
         end
         mtwg_pkg::ST_GAIN: begin
            mul_a    = sum_ff;
            mul_b    = mtwg_pkg::MulBW'(gain);
            state_in = mtwg_pkg::ST_RESULT;
         end
         mtwg_pkg::ST_RESULT: begin
            // keep the gain product in place while the output is blocked
            mul_a = sum_ff;
            mul_b = mtwg_pkg::MulBW'(gain);
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = mtwg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtwg_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtwg_pkg::ST_IDLE;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      t_ff   <= t_in;
      q_ff   <= q_in;
      t2_ff  <= t2_in;
   end

   // phase accumulators, all advanced together on a tick
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mtwg_pkg::Components; i++) begin
            phase_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < mtwg_pkg::Components; i++) begin
            phase_ff[i] <= phase_ff[i] + setup_ff[i][31:0];
         end
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mtwg_pkg::SetupRegs; i++) begin
            setup_ff[i] <= '0;
         end
         gain_ff <= mtwg_pkg::GainReset;
         used_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mtwg_pkg::REG_SETUP_A: setup_ff[0] <= csr_wdata;
            mtwg_pkg::REG_SETUP_B: setup_ff[1] <= csr_wdata;
            mtwg_pkg::REG_SETUP_C: setup_ff[2] <= csr_wdata;
            mtwg_pkg::REG_SETUP_D: setup_ff[3] <= csr_wdata;
            mtwg_pkg::REG_GAIN:    gain_ff     <= csr_wdata[mtwg_pkg::GainW-1:0];
            mtwg_pkg::REG_USED:    used_ff     <= csr_wdata[mtwg_pkg::UsedW-1:0];
            default: begin
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sample_ff <= y_clip;
         rsp_sat_ff    <= y_sat;
      end
   end

   assign req_stall        = (state_ff != mtwg_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_sample_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

// ===== hdl/mtwg_checker.sv =====
// ----------------------------------------------------------------------------
// mtwg_checker: port-level checks of the multi-tone wave generator
// watches the tick, sample and register channels over time
// ----------------------------------------------------------------------------
module mtwg_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_tick,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [31:0]                  rsp_sample_value,
   input  logic                                rsp_saturated,
   input  logic                                csr_valid,
   input  logic                                csr_ready
);

   // a blocked sample holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_value)
                                 && $stable(rsp_saturated))
      else $error("blocked sample transaction changed");

   // with these widths the gained sum never leaves the sample range
   a_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_saturated)
      else $error("sample reported as clipped");

   // a tick keeps the block busy for at least the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_tick |=> req_stall)
      else $error("tick taken without starting a sample");

   // an empty transaction leaves the block idle
   a_idle_stays: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_tick |=> !req_stall)
      else $error("empty transaction started work");

   // register writes are never held off
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write transaction held off");

endmodule

bind multi_tone_wave_generator mtwg_checker u_checker (.*);
